// ===== design/assert_macros.svh =====
// assert_macros.svh: assertion macros shared by the tape record deframer RTL.
// Depends on nothing; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every clock edge outside reset.
`define TRD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Same-cycle implication checked outside reset.
`define TRD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

// Next-cycle implication checked outside reset.
`define TRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define TRD_ASSERT(label, clk, rst, prop)
`define TRD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TRD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/trd_pkg.sv =====
// trd_pkg: types, codes and constants of the tape record deframer.
// Used by trd_core and tape_record_deframer; depends on nothing.
`default_nettype none

package trd_pkg;

  // Record layout
  localparam int unsigned NAME_BYTES   = 8;
  localparam int unsigned HEADER_BYTES = 6;
  localparam int unsigned MAX_DATA     = 256;
  localparam int unsigned CNT_W        = 9;

  localparam logic [7:0] LEADER_BYTE = 8'hE6;
  localparam logic [7:0] SOH_BYTE    = 8'h01;

  // Header byte positions
  localparam logic [CNT_W-1:0] HDR_NUM_LO  = 9'd0;
  localparam logic [CNT_W-1:0] HDR_NUM_HI  = 9'd1;
  localparam logic [CNT_W-1:0] HDR_LENGTH  = 9'd2;
  localparam logic [CNT_W-1:0] HDR_ADDR_LO = 9'd3;
  localparam logic [CNT_W-1:0] HDR_ADDR_HI = 9'd4;

  // Field class codes
  localparam logic [2:0] CLS_LEADER = 3'd0;
  localparam logic [2:0] CLS_SOH    = 3'd1;
  localparam logic [2:0] CLS_NAME   = 3'd2;
  localparam logic [2:0] CLS_HEADER = 3'd3;
  localparam logic [2:0] CLS_HSUM   = 3'd4;
  localparam logic [2:0] CLS_DATA   = 3'd5;
  localparam logic [2:0] CLS_DSUM   = 3'd6;
  localparam logic [2:0] CLS_NONE   = 3'd7;

  // Scan status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_HDR_FAIL   = 3'd1;
  localparam logic [2:0] ST_DATA_FAIL  = 3'd2;
  localparam logic [2:0] ST_BAD_LEADER = 3'd3;
  localparam logic [2:0] ST_EMPTY      = 3'd4;
  localparam logic [2:0] ST_NO_SOH     = 3'd5;
  localparam logic [2:0] ST_TRUNCATED  = 3'd6;

  // Framing phase, one-hot
  typedef enum logic [5:0] {
    PH_HUNT   = 6'b000001,
    PH_NAME   = 6'b000010,
    PH_HEADER = 6'b000100,
    PH_HSUM   = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_DSUM   = 6'b100000
  } phase_t;

  // One result transaction
  typedef struct packed {
    logic [7:0]       byte_value;
    logic [2:0]       field_class;
    logic [7:0]       field_position;
    logic             record_done;
    logic [2:0]       scan_status;
    logic [15:0]      record_number;
    logic [15:0]      load_address;
    logic [7:0]       record_kind;
    logic [CNT_W-1:0] data_count;
  } result_t;

endpackage

`default_nettype wire

// ===== design/trd_core.sv =====
// trd_core: framing state and per-byte classification of the deframer.
// Depends on trd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module trd_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic [7:0]       tape_byte,
  input  wire logic             end_of_input,
  input  wire logic             repair_length,
  output trd_pkg::result_t      res
);

  trd_pkg::phase_t               phase, phase_next;
  logic [trd_pkg::CNT_W-1:0]     byte_counter, byte_counter_next;
  logic [trd_pkg::CNT_W-1:0]     cnt_inc;
  logic [7:0]                    header_sum, header_sum_next;
  logic [7:0]                    data_sum, data_sum_next;
  logic                          leader_seen, leader_seen_next;
  logic [15:0]                   number_reg, number_reg_next;
  logic [15:0]                   address_reg, address_reg_next;
  logic [7:0]                    kind_reg, kind_reg_next;
  logic [trd_pkg::CNT_W-1:0]     length_reg, length_reg_next;
  logic                          header_bad, header_bad_next;
  logic [7:0]                    hsum_add, dsum_add;
  logic                          in_record;

  assign cnt_inc   = byte_counter + 9'd1;
  assign hsum_add  = header_sum + tape_byte;
  assign dsum_add  = data_sum + tape_byte;
  assign in_record = (phase == trd_pkg::PH_NAME) || (phase == trd_pkg::PH_HEADER) ||
                     (phase == trd_pkg::PH_HSUM) || (phase == trd_pkg::PH_DATA) ||
                     (phase == trd_pkg::PH_DSUM);

  // Next state and result for the byte at the input
  always_comb begin
    phase_next        = phase;
    byte_counter_next = byte_counter;
    header_sum_next   = header_sum;
    data_sum_next     = data_sum;
    leader_seen_next  = leader_seen;
    number_reg_next   = number_reg;
    address_reg_next  = address_reg;
    kind_reg_next     = kind_reg;
    length_reg_next   = length_reg;
    header_bad_next   = header_bad;

    res                = '0;
    res.byte_value     = tape_byte;
    res.field_class    = trd_pkg::CLS_NONE;
    res.field_position = 8'd0;
    res.record_done    = 1'b0;
    res.scan_status    = trd_pkg::ST_OK;

    if (end_of_input) begin
      res.byte_value  = 8'd0;
      res.record_done = 1'b1;
      if (in_record) begin
        res.scan_status = trd_pkg::ST_TRUNCATED;
      end else begin
        res.scan_status = leader_seen ? trd_pkg::ST_NO_SOH : trd_pkg::ST_EMPTY;
      end
    end else begin
      case (phase)
        trd_pkg::PH_NAME: begin
          res.field_class    = trd_pkg::CLS_NAME;
          res.field_position = byte_counter[7:0];
          header_sum_next    = hsum_add;
          if (cnt_inc >= trd_pkg::CNT_W'(trd_pkg::NAME_BYTES)) begin
            phase_next        = trd_pkg::PH_HEADER;
            byte_counter_next = '0;
          end else begin
            byte_counter_next = cnt_inc;
          end
        end
        trd_pkg::PH_HEADER: begin
          res.field_class    = trd_pkg::CLS_HEADER;
          res.field_position = byte_counter[7:0];
          header_sum_next    = hsum_add;
          case (byte_counter)
            trd_pkg::HDR_NUM_LO:  number_reg_next  = {number_reg[15:8], tape_byte};
            trd_pkg::HDR_NUM_HI:  number_reg_next  = {tape_byte, number_reg[7:0]};
            trd_pkg::HDR_LENGTH:  length_reg_next  = (tape_byte == 8'd0) ?
                                    trd_pkg::CNT_W'(trd_pkg::MAX_DATA) : {1'b0, tape_byte};
            trd_pkg::HDR_ADDR_LO: address_reg_next = {address_reg[15:8], tape_byte};
            trd_pkg::HDR_ADDR_HI: address_reg_next = {tape_byte, address_reg[7:0]};
            default:              kind_reg_next    = tape_byte;
          endcase
          if (cnt_inc >= trd_pkg::CNT_W'(trd_pkg::HEADER_BYTES)) begin
            phase_next        = trd_pkg::PH_HSUM;
            byte_counter_next = '0;
          end else begin
            byte_counter_next = cnt_inc;
          end
        end
        trd_pkg::PH_HSUM: begin
          res.field_class   = trd_pkg::CLS_HSUM;
          header_sum_next   = hsum_add;
          header_bad_next   = (hsum_add != 8'd0);
          if ((hsum_add != 8'd0) && repair_length) begin
            length_reg_next = trd_pkg::CNT_W'(trd_pkg::MAX_DATA);
          end
          byte_counter_next = '0;
          phase_next = (length_reg_next == '0) ? trd_pkg::PH_DSUM : trd_pkg::PH_DATA;
        end
        trd_pkg::PH_DATA: begin
          res.field_class    = trd_pkg::CLS_DATA;
          res.field_position = byte_counter[7:0];
          data_sum_next      = dsum_add;
          if (cnt_inc >= length_reg) begin
            phase_next        = trd_pkg::PH_DSUM;
            byte_counter_next = '0;
          end else begin
            byte_counter_next = cnt_inc;
          end
        end
        trd_pkg::PH_DSUM: begin
          res.field_class = trd_pkg::CLS_DSUM;
          data_sum_next   = dsum_add;
          res.record_done = 1'b1;
          if (header_bad) begin
            res.scan_status = trd_pkg::ST_HDR_FAIL;
          end else if (dsum_add != 8'd0) begin
            res.scan_status = trd_pkg::ST_DATA_FAIL;
          end else begin
            res.scan_status = trd_pkg::ST_OK;
          end
        end
        default: begin
          // hunting for leader and SOH
          if (tape_byte == trd_pkg::LEADER_BYTE) begin
            res.field_class  = trd_pkg::CLS_LEADER;
            leader_seen_next = 1'b1;
          end else if (tape_byte == trd_pkg::SOH_BYTE) begin
            res.field_class   = trd_pkg::CLS_SOH;
            phase_next        = trd_pkg::PH_NAME;
            byte_counter_next = '0;
            header_sum_next   = 8'd0;
            data_sum_next     = 8'd0;
            number_reg_next   = 16'd0;
            address_reg_next  = 16'd0;
            kind_reg_next     = 8'd0;
            length_reg_next   = '0;
            header_bad_next   = 1'b0;
          end else begin
            res.record_done = 1'b1;
            res.scan_status = trd_pkg::ST_BAD_LEADER;
          end
        end
      endcase
    end

    // header as captured after this byte
    res.record_number = number_reg_next;
    res.load_address  = address_reg_next;
    res.record_kind   = kind_reg_next;
    res.data_count    = length_reg_next;
  end

  // State registers; a finished record clears everything
  always_ff @(posedge clk) begin
    if (rst || (step && res.record_done)) begin
      phase        <= trd_pkg::PH_HUNT;
      byte_counter <= '0;
      header_sum   <= 8'd0;
      data_sum     <= 8'd0;
      leader_seen  <= 1'b0;
      number_reg   <= 16'd0;
      address_reg  <= 16'd0;
      kind_reg     <= 8'd0;
      length_reg   <= '0;
      header_bad   <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      byte_counter <= byte_counter_next;
      header_sum   <= header_sum_next;
      data_sum     <= data_sum_next;
      leader_seen  <= leader_seen_next;
      number_reg   <= number_reg_next;
      address_reg  <= address_reg_next;
      kind_reg     <= kind_reg_next;
      length_reg   <= length_reg_next;
      header_bad   <= header_bad_next;
    end
  end

  // Checks
  `TRD_ASSERT_NEXT(a_done_clears, clk, rst, step && res.record_done,
                   phase == trd_pkg::PH_HUNT && byte_counter == '0 && !leader_seen)
  `TRD_ASSERT_IMPL(a_data_len_set, clk, rst, phase == trd_pkg::PH_DATA,
                   length_reg != '0 && byte_counter < length_reg)
  `TRD_ASSERT(a_phase_onehot, clk, rst, $onehot(phase))

endmodule

`default_nettype wire

// ===== design/tape_record_deframer.sv =====
// tape_record_deframer: top level with input register, framing core and result register.
// Depends on trd_pkg, trd_core and assert_macros.svh.
//
// Frames cassette records (leader 0xE6 bytes, SOH 0x01, name, six header
// bytes, header checksum, data, data checksum) from a byte stream and tags
// every byte with its field and position; record_done marks the end of a
// record or of a failed scan, with scan_status and the decoded header.
// Throughput is one byte transaction per clock while out_ready does not stall
// the result register: the framing update is a single 8-bit add, a 9-bit
// count compare and a phase change between the input register and the result
// register. An accepted byte is held in the input register, and its result is
// written to the result register when the core steps. Both sides are
// registered, so a stalled result holds while one further byte waits in the
// input register. repair_length is written through cfg_wen/cfg_wdata; the user
// must write it only while the block is idle; the block does not enforce this.
`default_nettype none
`include "assert_macros.svh"

module tape_record_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_wen,
  input  wire logic        cfg_wdata,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  tape_byte,
  input  wire logic        end_of_input,
  // output channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       byte_value,
  output logic [2:0]       field_class,
  output logic [7:0]       field_position,
  output logic             record_done,
  output logic [2:0]       scan_status,
  output logic [15:0]      record_number,
  output logic [15:0]      load_address,
  output logic [7:0]       record_kind,
  output logic [8:0]       data_count
);

  logic             repair_length;
  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             s1_eoi;
  logic             advance;
  trd_pkg::result_t res;
  trd_pkg::result_t res_q;

  // Core steps when the input stage holds a byte and the result slot is free
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      repair_length <= 1'b0;
    end else if (cfg_wen) begin
      repair_length <= cfg_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= tape_byte;
      s1_eoi  <= end_of_input;
    end
  end

  trd_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .tape_byte     (s1_byte),
    .end_of_input  (s1_eoi),
    .repair_length (repair_length),
    .res           (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign byte_value     = res_q.byte_value;
  assign field_class    = res_q.field_class;
  assign field_position = res_q.field_position;
  assign record_done    = res_q.record_done;
  assign scan_status    = res_q.scan_status;
  assign record_number  = res_q.record_number;
  assign load_address   = res_q.load_address;
  assign record_kind    = res_q.record_kind;
  assign data_count     = res_q.data_count;

  // Checks
  `TRD_ASSERT_IMPL(a_status_only_when_done, clk, rst, out_valid && !record_done,
                   scan_status == trd_pkg::ST_OK)
  `TRD_ASSERT_IMPL(a_pos_zero_outside_fields, clk, rst,
                   out_valid && (field_class == trd_pkg::CLS_LEADER ||
                   field_class == trd_pkg::CLS_SOH || field_class == trd_pkg::CLS_HSUM ||
                   field_class == trd_pkg::CLS_DSUM || field_class == trd_pkg::CLS_NONE),
                   field_position == 8'd0)
  `TRD_ASSERT(a_stall_means_full, clk, rst, in_ready || (s1_valid && out_valid))

endmodule

`default_nettype wire

// ===== tb/tb_tape_record_deframer.sv =====
// tb_tape_record_deframer: self-checking bench for the tape record deframer, byte stream in,
// tagged byte plus record status out, with a byte-level framing predictor and random stalls.
// Depends on trd_pkg and the tape_record_deframer RTL.
`default_nettype none

module tb_tape_record_deframer;
  import trd_pkg::*;

  // One stimulus row; want is used only when the expectation is typed in
  typedef struct packed {
    logic [7:0] b;
    logic       eoi;
    logic       lit;
    result_t    want;
  } tape_row_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_wen = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] tape_byte = 8'h00;
  logic       end_of_input = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] byte_value;
  logic [2:0] field_class;
  logic [7:0] field_position;
  logic       record_done;
  logic [2:0] scan_status;
  logic [15:0] record_number;
  logic [15:0] load_address;
  logic [7:0] record_kind;
  logic [8:0] data_count;

  tape_record_deframer u_top (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .tape_byte(tape_byte), .end_of_input(end_of_input),
    .out_valid(out_valid), .out_ready(out_ready),
    .byte_value(byte_value), .field_class(field_class), .field_position(field_position),
    .record_done(record_done), .scan_status(scan_status),
    .record_number(record_number), .load_address(load_address),
    .record_kind(record_kind), .data_count(data_count)
  );

  // Predictor copy of the framing state and the repair setting
  phase_t      fr_phase;
  logic [8:0]  fr_count;
  logic [7:0]  hdr_acc;
  logic [7:0]  dat_acc;
  logic        leader_hit;
  logic [15:0] num_q;
  logic [15:0] addr_q;
  logic [7:0]  kind_q;
  logic [8:0]  len_q;
  logic        hdr_fail;
  logic        repair_on;

  result_t   pending_results[$];
  result_t   seen;
  result_t   want;
  tape_row_t directed_rows[$];
  logic      quiet = 1'b0;
  int        mismatches = 0;
  int        bytes_sent = 0;
  int        results_seen = 0;
  int        records_seen = 0;
  int        status_hits[8];
  int        stall_left = 0;
  int        phase_budget[4] = '{500, 500, 300, 200};

  assign seen = {byte_value, field_class, field_position, record_done, scan_status,
                 record_number, load_address, record_kind, data_count};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  function automatic void clear_frame();
    fr_phase   = PH_HUNT;
    fr_count   = '0;
    hdr_acc    = '0;
    dat_acc    = '0;
    leader_hit = 1'b0;
    num_q      = '0;
    addr_q     = '0;
    kind_q     = '0;
    len_q      = '0;
    hdr_fail   = 1'b0;
  endfunction

  // Advance the framing state by one byte transaction and return its tagged result
  function automatic result_t frame_byte(input logic [7:0] b, input logic eoi);
    result_t r;
    r = '0;
    r.byte_value  = b;
    r.field_class = CLS_NONE;
    if (eoi) begin
      r.byte_value  = 8'h00;
      r.record_done = 1'b1;
      if (fr_phase == PH_HUNT) r.scan_status = leader_hit ? ST_NO_SOH : ST_EMPTY;
      else r.scan_status = ST_TRUNCATED;
    end else begin
      case (fr_phase)
        PH_NAME: begin
          r.field_class    = CLS_NAME;
          r.field_position = fr_count[7:0];
          hdr_acc  = hdr_acc + b;
          fr_count = fr_count + 9'd1;
          if (fr_count >= NAME_BYTES) begin
            fr_phase = PH_HEADER;
            fr_count = '0;
          end
        end
        PH_HEADER: begin
          r.field_class    = CLS_HEADER;
          r.field_position = fr_count[7:0];
          hdr_acc = hdr_acc + b;
          case (fr_count)
            HDR_NUM_LO:  num_q[7:0]   = b;
            HDR_NUM_HI:  num_q[15:8]  = b;
            HDR_LENGTH:  len_q        = (b == 8'h00) ? 9'(MAX_DATA) : {1'b0, b};
            HDR_ADDR_LO: addr_q[7:0]  = b;
            HDR_ADDR_HI: addr_q[15:8] = b;
            default:     kind_q       = b;
          endcase
          fr_count = fr_count + 9'd1;
          if (fr_count >= HEADER_BYTES) begin
            fr_phase = PH_HSUM;
            fr_count = '0;
          end
        end
        PH_HSUM: begin
          r.field_class = CLS_HSUM;
          hdr_acc  = hdr_acc + b;
          hdr_fail = (hdr_acc != 8'h00);
          if (hdr_fail && repair_on) len_q = 9'(MAX_DATA);
          fr_count = '0;
          fr_phase = (len_q == '0) ? PH_DSUM : PH_DATA;
        end
        PH_DATA: begin
          r.field_class    = CLS_DATA;
          r.field_position = fr_count[7:0];
          dat_acc  = dat_acc + b;
          fr_count = fr_count + 9'd1;
          if (fr_count >= len_q) begin
            fr_phase = PH_DSUM;
            fr_count = '0;
          end
        end
        PH_DSUM: begin
          r.field_class = CLS_DSUM;
          dat_acc = dat_acc + b;
          r.record_done = 1'b1;
          // header failure takes precedence over a data failure
          if (hdr_fail) r.scan_status = ST_HDR_FAIL;
          else if (dat_acc != 8'h00) r.scan_status = ST_DATA_FAIL;
          else r.scan_status = ST_OK;
        end
        default: begin
          if (b == LEADER_BYTE) begin
            r.field_class = CLS_LEADER;
            leader_hit = 1'b1;
          end else if (b == SOH_BYTE) begin
            clear_frame();
            r.field_class = CLS_SOH;
            fr_phase = PH_NAME;
          end else begin
            r.record_done = 1'b1;
            r.scan_status = ST_BAD_LEADER;
          end
        end
      endcase
    end
    r.record_number = num_q;
    r.load_address  = addr_q;
    r.record_kind   = kind_q;
    r.data_count    = len_q;
    if (r.record_done) begin
      clear_frame();
    end
    return r;
  endfunction

  function automatic tape_row_t row(input logic [7:0] b, input logic eoi);
    tape_row_t t;
    t = '0;
    t.b   = b;
    t.eoi = eoi;
    return t;
  endfunction

  // Row with its expectation typed in; header fields are all zero in these cases
  function automatic tape_row_t lit(input logic [7:0] b, input logic eoi, input logic [2:0] cls,
                                    input logic done, input logic [2:0] st);
    tape_row_t t;
    t = row(b, eoi);
    t.lit = 1'b1;
    t.want.byte_value  = eoi ? 8'h00 : b;
    t.want.field_class = cls;
    t.want.record_done = done;
    t.want.scan_status = st;
    return t;
  endfunction

  // Present one byte transaction, wait for acceptance, queue its expectation
  task automatic push_byte(input tape_row_t t);
    result_t predicted;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    tape_byte    <= t.b;
    end_of_input <= t.eoi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = frame_byte(t.b, t.eoi);
    pending_results.insert(pending_results.size(), t.lit ? t.want : predicted);
    bytes_sent++;
  endtask

  // Hold off the sender until every queued result has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_repair(input logic v);
    drain();
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    repair_on = v;
  endtask

  // Random records: leaders, SOH, name, header, sums and data, with some noise,
  // bad checksums and truncation mixed in
  task automatic run_records(input int budget, input logic allow_long);
    tape_row_t  rec_q[$];
    int         start;
    int         rec_no;
    int         eff;
    int         soh_idx;
    int         cut;
    int         pick;
    logic [7:0] b;
    logic [7:0] len_b;
    logic [7:0] hsum;
    logic [7:0] dsum;
    logic       hdr_bad;
    logic       dat_bad;
    start  = bytes_sent;
    rec_no = 0;
    while (bytes_sent - start < budget) begin
      // noise between records
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3))
          push_byte(row(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0));
      end
      // noise may have opened a record; close it so the next one frames cleanly
      if (fr_phase != PH_HUNT) push_byte(row(8'($urandom_range(0, 255)), 1'b1));

      rec_q = {};
      repeat ($urandom_range(0, 4)) rec_q.insert(rec_q.size(), row(LEADER_BYTE, 1'b0));
      soh_idx = rec_q.size();
      rec_q.insert(rec_q.size(), row(SOH_BYTE, 1'b0));
      hsum = 8'h00;
      for (int i = 0; i < NAME_BYTES; i++) begin
        b = 8'($urandom_range(0, 255));
        hsum = hsum + b;
        rec_q.insert(rec_q.size(), row(b, 1'b0));
      end
      pick = $urandom_range(0, 39);
      if (allow_long && (rec_no == 0 || pick == 0)) len_b = 8'h00;
      else if (allow_long && pick == 1) len_b = 8'hFF;
      else len_b = 8'($urandom_range(1, 12));
      for (int i = 0; i < HEADER_BYTES; i++) begin
        b = (i == HDR_LENGTH) ? len_b : 8'($urandom_range(0, 255));
        hsum = hsum + b;
        rec_q.insert(rec_q.size(), row(b, 1'b0));
      end
      // a repaired bad header costs a full 256-byte data field, so keep it rare
      hdr_bad = (rec_no == 1) || ($urandom_range(0, repair_on ? 24 : 7) == 0);
      dat_bad = ($urandom_range(0, 5) == 0);
      b = 8'h00 - hsum;
      if (hdr_bad) b = b + 8'($urandom_range(1, 255));
      rec_q.insert(rec_q.size(), row(b, 1'b0));
      eff = (len_b == 8'h00) ? MAX_DATA : int'(len_b);
      if (hdr_bad && repair_on) eff = MAX_DATA;
      dsum = 8'h00;
      for (int i = 0; i < eff; i++) begin
        b = 8'($urandom_range(0, 255));
        dsum = dsum + b;
        rec_q.insert(rec_q.size(), row(b, 1'b0));
      end
      b = 8'h00 - dsum;
      if (dat_bad) b = b + 8'($urandom_range(1, 255));
      rec_q.insert(rec_q.size(), row(b, 1'b0));
      // truncated record: end of input somewhere after SOH
      if ($urandom_range(0, 7) == 0) begin
        cut = $urandom_range(soh_idx + 1, rec_q.size() - 1);
        while (rec_q.size() > cut) void'(rec_q.pop_back());
        rec_q.insert(rec_q.size(), row(8'($urandom_range(0, 255)), 1'b1));
      end
      foreach (rec_q[i]) push_byte(rec_q[i]);
      rec_no++;
    end
  endtask

  // Result monitor and receiver stall bursts
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (record_done) begin
        records_seen++;
        status_hits[scan_status]++;
      end
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: byte %h class %0d", byte_value,
                                       field_class);
      end else begin
        want = pending_results.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at result %0d", results_seen);
            $display("  expected byte %h cls %0d pos %0d done %b st %0d num %h addr %h kind %h cnt %0d",
                     want.byte_value, want.field_class, want.field_position, want.record_done,
                     want.scan_status, want.record_number, want.load_address,
                     want.record_kind, want.data_count);
            $display("  actual   byte %h cls %0d pos %0d done %b st %0d num %h addr %h kind %h cnt %0d",
                     seen.byte_value, seen.field_class, seen.field_position, seen.record_done,
                     seen.scan_status, seen.record_number, seen.load_address,
                     seen.record_kind, seen.data_count);
          end
        end
      end
    end
    if (!quiet && stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 15) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Main sequence
  initial begin
    foreach (status_hits[i]) status_hits[i] = 0;
    repair_on = 1'b0;
    clear_frame();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    set_repair(1'b0);

    // hunting-state cases and a truncation, expectations typed in
    directed_rows.insert(directed_rows.size(), lit(8'h5A, 1'b1, CLS_NONE, 1'b1, ST_EMPTY));
    directed_rows.insert(directed_rows.size(), lit(LEADER_BYTE, 1'b0, CLS_LEADER, 1'b0, ST_OK));
    directed_rows.insert(directed_rows.size(), lit(8'h00, 1'b1, CLS_NONE, 1'b1, ST_NO_SOH));
    directed_rows.insert(directed_rows.size(), lit(8'h00, 1'b0, CLS_NONE, 1'b1, ST_BAD_LEADER));
    directed_rows.insert(directed_rows.size(), lit(LEADER_BYTE, 1'b0, CLS_LEADER, 1'b0, ST_OK));
    directed_rows.insert(directed_rows.size(), lit(8'hFF, 1'b0, CLS_NONE, 1'b1, ST_BAD_LEADER));
    directed_rows.insert(directed_rows.size(), lit(SOH_BYTE, 1'b0, CLS_SOH, 1'b0, ST_OK));
    directed_rows.insert(directed_rows.size(), lit(8'hFF, 1'b1, CLS_NONE, 1'b1, ST_TRUNCATED));
    // full record, one data byte, both checksums wrong
    directed_rows.insert(directed_rows.size(), row(SOH_BYTE, 1'b0));
    for (int i = 0; i < NAME_BYTES; i++)
      directed_rows.insert(directed_rows.size(), row(i[0] ? 8'hFF : 8'h00, 1'b0));
    directed_rows.insert(directed_rows.size(), row(8'hFF, 1'b0));
    directed_rows.insert(directed_rows.size(), row(8'h80, 1'b0));
    directed_rows.insert(directed_rows.size(), row(8'h01, 1'b0));
    directed_rows.insert(directed_rows.size(), row(8'h00, 1'b0));
    directed_rows.insert(directed_rows.size(), row(8'hFF, 1'b0));
    directed_rows.insert(directed_rows.size(), row(8'h7F, 1'b0));
    directed_rows.insert(directed_rows.size(), row(8'h00, 1'b0));
    directed_rows.insert(directed_rows.size(), row(8'hAA, 1'b0));
    directed_rows.insert(directed_rows.size(), row(8'h00, 1'b0));
    foreach (directed_rows[i]) push_byte(directed_rows[i]);

    // repair off/on alternating, last phase without any idling
    for (int ph = 0; ph < 4; ph++) begin
      set_repair(ph[0]);
      quiet = (ph == 3);
      run_records(phase_budget[ph], ph < 2);
    end

    drain();
    repeat (10) @(posedge clk);
    $display("%0d byte transactions, %0d results, %0d record ends, repair off and on",
             bytes_sent, results_seen, records_seen);
    $display("status ok %0d hdr %0d data %0d leader %0d empty %0d no-soh %0d trunc %0d",
             status_hits[ST_OK], status_hits[ST_HDR_FAIL], status_hits[ST_DATA_FAIL],
             status_hits[ST_BAD_LEADER], status_hits[ST_EMPTY], status_hits[ST_NO_SOH],
             status_hits[ST_TRUNCATED]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== tape_record_deframer.f =====
+incdir+design
design/trd_pkg.sv
design/trd_core.sv
design/tape_record_deframer.sv
tb/tb_tape_record_deframer.sv
